// File: rtl/assert_macros.svh
// Assertion helpers used by the checker file vnorm_chk.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every rising clock edge outside reset.
`define CHK_ALWAYS(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CHK_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/vnorm_pkg.sv
package vnorm_pkg;

   localparam int DEF_FIXED_SCALE = 1024;
   localparam int DEF_COORD_BITS  = 16;
   localparam int IN_W            = 16;
   localparam int OUT_W           = 12;
   localparam int OUT_MAX         = 2047;
   localparam int QMAX_W          = 14;

   typedef struct packed {
      logic signed [IN_W-1:0] dir_x;
      logic signed [IN_W-1:0] dir_y;
   } req_type;

   typedef struct packed {
      logic signed [OUT_W-1:0] unit_x;
      logic signed [OUT_W-1:0] unit_y;
   } rsp_type;

   // Apply sign to a quotient magnitude and clamp to the output range.
   function automatic logic signed [OUT_W-1:0] sat_out(input logic [QMAX_W-1:0] q,
                                                       input logic neg);
      logic [QMAX_W-1:0] lim;
      logic [QMAX_W-1:0] m;
      lim = neg ? QMAX_W'(OUT_MAX + 1) : QMAX_W'(OUT_MAX);
      m   = (q > lim) ? lim : q;
      sat_out = neg ? OUT_W'(-m) : OUT_W'(m);
   endfunction

endpackage

// File: rtl/vnorm_sqrt.sv
module vnorm_sqrt #(
   parameter int RAD_W  = 56,
   parameter int SIDE_W = 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic                 in_valid,
   input  logic [RAD_W-1:0]     in_rad,
   input  logic [SIDE_W-1:0]    in_side,
   output logic                 out_valid,
   output logic [RAD_W/2-1:0]   out_root,
   output logic [SIDE_W-1:0]    out_side
);

   localparam int ROOT_W = RAD_W / 2;

   logic [RAD_W-1:0]  rem_ff  [ROOT_W];
   logic [RAD_W-1:0]  res_ff  [ROOT_W];
   logic [SIDE_W-1:0] side_ff [ROOT_W];
   logic              vld_ff  [ROOT_W];

   // One result bit per stage.
   for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
      localparam logic [RAD_W-1:0] BIT =
         {{(RAD_W-1){1'b0}}, 1'b1} << (2 * (ROOT_W - 1 - k));
      logic [RAD_W-1:0]  p_rem;
      logic [RAD_W-1:0]  p_res;
      logic [SIDE_W-1:0] p_side;
      logic              p_vld;
      logic [RAD_W-1:0]  trial;
      logic [RAD_W-1:0]  rem_in;
      logic [RAD_W-1:0]  res_in;

      if (k == 0) begin : g_first
         assign p_rem  = in_rad;
         assign p_res  = '0;
         assign p_side = in_side;
         assign p_vld  = in_valid;
      end else begin : g_next
         assign p_rem  = rem_ff[k-1];
         assign p_res  = res_ff[k-1];
         assign p_side = side_ff[k-1];
         assign p_vld  = vld_ff[k-1];
      end

      always_comb begin
         trial = p_res + BIT;
         if (p_rem >= trial) begin
            rem_in = p_rem - trial;
            res_in = (p_res >> 1) + BIT;
         end else begin
            rem_in = p_rem;
            res_in = p_res >> 1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (en) begin
            vld_ff[k] <= p_vld;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k]  <= rem_in;
            res_ff[k]  <= res_in;
            side_ff[k] <= p_side;
         end
      end
   end

   assign out_valid = vld_ff[ROOT_W-1];
   assign out_root  = res_ff[ROOT_W-1][ROOT_W-1:0];
   assign out_side  = side_ff[ROOT_W-1];

endmodule

// File: rtl/vnorm_div.sv
module vnorm_div #(
   parameter int NUM_W  = 40,
   parameter int DEN_W  = 28,
   parameter int Q_W    = 11,
   parameter int SIDE_W = 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  logic [NUM_W-1:0]  in_num,
   input  logic [DEN_W-1:0]  in_den,
   input  logic [SIDE_W-1:0] in_side,
   output logic              out_valid,
   output logic [Q_W-1:0]    out_quot,
   output logic [SIDE_W-1:0] out_side
);

   localparam int CMP_W = (NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W;

   logic [CMP_W-1:0]  rem_ff  [Q_W];
   logic [DEN_W-1:0]  den_ff  [Q_W];
   logic [Q_W-1:0]    quot_ff [Q_W];
   logic [SIDE_W-1:0] side_ff [Q_W];
   logic              vld_ff  [Q_W];

   // Restoring division, one quotient bit per stage, msb first.
   for (genvar k = 0; k < Q_W; k++) begin : g_stage
      localparam int SH = Q_W - 1 - k;
      logic [CMP_W-1:0]  p_rem;
      logic [DEN_W-1:0]  p_den;
      logic [Q_W-1:0]    p_quot;
      logic [SIDE_W-1:0] p_side;
      logic              p_vld;
      logic [CMP_W-1:0]  dsh;
      logic [CMP_W-1:0]  rem_in;
      logic [Q_W-1:0]    quot_in;

      if (k == 0) begin : g_first
         assign p_rem  = CMP_W'(in_num);
         assign p_den  = in_den;
         assign p_quot = '0;
         assign p_side = in_side;
         assign p_vld  = in_valid;
      end else begin : g_next
         assign p_rem  = rem_ff[k-1];
         assign p_den  = den_ff[k-1];
         assign p_quot = quot_ff[k-1];
         assign p_side = side_ff[k-1];
         assign p_vld  = vld_ff[k-1];
      end

      always_comb begin
         dsh     = CMP_W'(p_den) << SH;
         rem_in  = p_rem;
         quot_in = p_quot;
         if (p_rem >= dsh) begin
            rem_in      = p_rem - dsh;
            quot_in[SH] = 1'b1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (en) begin
            vld_ff[k] <= p_vld;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k]  <= rem_in;
            den_ff[k]  <= p_den;
            quot_ff[k] <= quot_in;
            side_ff[k] <= p_side;
         end
      end
   end

   assign out_valid = vld_ff[Q_W-1];
   assign out_quot  = quot_ff[Q_W-1];
   assign out_side  = side_ff[Q_W-1];

endmodule

// File: rtl/fixed_point_vector_normalize.sv
// Pipeline: input stages, ROOT_W root stages, Q_W divider stages and an output
// register; ROOT_W = COORD_BITS + clog2(FIXED_SCALE+1), Q_W = clog2(FIXED_SCALE+1).
// Throughput: one item per cycle; the bit-per-stage root and divider pipelines
// take a new item every cycle and the whole pipeline holds while rsp is stalled.
// Reset: synchronous, active high; clears all valid bits, payload is not reset.
module fixed_point_vector_normalize
   import vnorm_pkg::*;
#(
   parameter int FIXED_SCALE = DEF_FIXED_SCALE,
   parameter int COORD_BITS  = DEF_COORD_BITS
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int SC_W   = $clog2(FIXED_SCALE + 1);
   localparam int S2_W   = 2 * SC_W;
   localparam int SQ_W   = 2 * COORD_BITS;
   localparam int RAD_W  = SQ_W + S2_W;
   localparam int ROOT_W = RAD_W / 2;
   localparam int NUM_W  = COORD_BITS + S2_W;
   localparam int Q_W    = SC_W;
   localparam int SIDE_W = 2 * NUM_W + 3;
   localparam logic [S2_W-1:0] SCALE_SQ = S2_W'(FIXED_SCALE * FIXED_SCALE);

   // Whole pipeline advances unless a finished item is held at the output.
   logic adv;
   assign adv       = !(rsp_valid && rsp_stall);
   assign req_stall = !adv;

   // Stage 1: take the low COORD_BITS of each coordinate.
   logic                         v1_ff;
   logic signed [COORD_BITS-1:0] cx_ff, cy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         cx_ff <= req_data.dir_x[COORD_BITS-1:0];
         cy_ff <= req_data.dir_y[COORD_BITS-1:0];
      end
   end

   // Stage 2: squares, magnitudes and signs.
   logic signed [SQ_W-1:0]  ex, ey;
   logic signed [SQ_W-1:0]  sqx_full, sqy_full;
   logic signed [COORD_BITS:0] wx, wy;
   logic [SQ_W-1:0]         sqx_ff, sqy_ff;
   logic [COORD_BITS-1:0]   magx_ff, magy_ff;
   logic                    sx2_ff, sy2_ff;
   logic                    v2_ff;

   always_comb begin
      ex       = SQ_W'(cx_ff);
      ey       = SQ_W'(cy_ff);
      sqx_full = ex * ex;
      sqy_full = ey * ey;
      wx       = (COORD_BITS + 1)'(cx_ff);
      wy       = (COORD_BITS + 1)'(cy_ff);
      if (cx_ff < 0) begin
         wx = -wx;
      end
      if (cy_ff < 0) begin
         wy = -wy;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (adv) begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sqx_ff  <= $unsigned(sqx_full);
         sqy_ff  <= $unsigned(sqy_full);
         magx_ff <= wx[COORD_BITS-1:0];
         magy_ff <= wy[COORD_BITS-1:0];
         sx2_ff  <= cx_ff[COORD_BITS-1];
         sy2_ff  <= cy_ff[COORD_BITS-1];
      end
   end

   // Stage 3: squared length and the scaled numerators.
   logic [SQ_W-1:0]  lensq_ff;
   logic [NUM_W-1:0] numx_ff, numy_ff;
   logic             sx3_ff, sy3_ff;
   logic             v3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (adv) begin
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         lensq_ff <= sqx_ff + sqy_ff;
         numx_ff  <= NUM_W'(magx_ff) * NUM_W'(SCALE_SQ);
         numy_ff  <= NUM_W'(magy_ff) * NUM_W'(SCALE_SQ);
         sx3_ff   <= sx2_ff;
         sy3_ff   <= sy2_ff;
      end
   end

   // Stage 4: radicand len_sq * S^2 and the zero-vector flag.
   logic [RAD_W-1:0] rad_ff;
   logic [NUM_W-1:0] numx4_ff, numy4_ff;
   logic             sx4_ff, sy4_ff, zero4_ff;
   logic             v4_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else if (adv) begin
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rad_ff   <= RAD_W'(lensq_ff) * RAD_W'(SCALE_SQ);
         zero4_ff <= (lensq_ff == '0);
         numx4_ff <= numx_ff;
         numy4_ff <= numy_ff;
         sx4_ff   <= sx3_ff;
         sy4_ff   <= sy3_ff;
      end
   end

   // Floor square root; numerators, signs and zero flag ride alongside.
   logic              sq_valid;
   logic [ROOT_W-1:0] root;
   logic [SIDE_W-1:0] sq_side;

   vnorm_sqrt #(
      .RAD_W  (RAD_W),
      .SIDE_W (SIDE_W)
   ) u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (v4_ff),
      .in_rad    (rad_ff),
      .in_side   ({numx4_ff, numy4_ff, sx4_ff, sy4_ff, zero4_ff}),
      .out_valid (sq_valid),
      .out_root  (root),
      .out_side  (sq_side)
   );

   logic [NUM_W-1:0] numx_s, numy_s;
   logic             sx_s, sy_s, zero_s;
   assign {numx_s, numy_s, sx_s, sy_s, zero_s} = sq_side;

   // Two dividers share the root; x carries its sign and the zero flag, y its sign.
   logic           dx_valid, dy_valid;
   logic [Q_W-1:0] qx, qy;
   logic [1:0]     dx_side;
   logic           dy_side;

   vnorm_div #(
      .NUM_W  (NUM_W),
      .DEN_W  (ROOT_W),
      .Q_W    (Q_W),
      .SIDE_W (2)
   ) u_div_x (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (sq_valid),
      .in_num    (numx_s),
      .in_den    (root),
      .in_side   ({sx_s, zero_s}),
      .out_valid (dx_valid),
      .out_quot  (qx),
      .out_side  (dx_side)
   );

   vnorm_div #(
      .NUM_W  (NUM_W),
      .DEN_W  (ROOT_W),
      .Q_W    (Q_W),
      .SIDE_W (1)
   ) u_div_y (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (sq_valid),
      .in_num    (numy_s),
      .in_den    (root),
      .in_side   (sy_s),
      .out_valid (dy_valid),
      .out_quot  (qy),
      .out_side  (dy_side)
   );

   // Output register: apply sign, saturate, force zero vector to (0, 0).
   logic    rsp_valid_ff;
   rsp_type rsp_data_ff;
   rsp_type rsp_data_in;

   always_comb begin
      rsp_data_in.unit_x = sat_out(QMAX_W'(qx), dx_side[1]);
      rsp_data_in.unit_y = sat_out(QMAX_W'(qy), dy_side);
      if (dx_side[0]) begin
         rsp_data_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= dx_valid && dy_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// File: rtl/vnorm_chk.sv
`include "assert_macros.svh"

module vnorm_chk
   import vnorm_pkg::*;
#(
   parameter int FIXED_SCALE = DEF_FIXED_SCALE
) (
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input req_type req_data,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   logic held;
   logic req_held;
   logic in_range;
   assign held     = rsp_valid && rsp_stall;
   assign req_held = req_valid && req_stall;
   assign in_range = (int'(rsp_data.unit_x) <= FIXED_SCALE)
                  && (int'(rsp_data.unit_x) >= -FIXED_SCALE)
                  && (int'(rsp_data.unit_y) <= FIXED_SCALE)
                  && (int'(rsp_data.unit_y) >= -FIXED_SCALE);

   `CHK_NEXT(a_rsp_hold, clock, reset, held, rsp_valid, "rsp item dropped while stalled")
   `CHK_NEXT(a_rsp_stable, clock, reset, held, $stable(rsp_data), "rsp item changed while stalled")
   `CHK_NEXT(a_req_stable, clock, reset, req_held, req_valid && $stable(req_data), "req item changed")
   `CHK_ALWAYS(a_req_stall_cause, clock, reset, !req_stall || held, "req stalled without output backpressure")
   `CHK_ALWAYS(a_unit_range, clock, reset, !rsp_valid || in_range, "unit component out of range")

endmodule

bind fixed_point_vector_normalize vnorm_chk #(
   .FIXED_SCALE (FIXED_SCALE)
) u_vnorm_chk (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
